/* rtl/core/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the single-wire sensor frame reader.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned FrameBits = 40;
  localparam int unsigned RegIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;

  // register indexes of the configuration port
  localparam logic [RegIdxW-1:0] RegStartLow   = 8'd0;
  localparam logic [RegIdxW-1:0] RegReleaseHigh = 8'd1;
  localparam logic [RegIdxW-1:0] RegOneThresh  = 8'd2;
  localparam logic [RegIdxW-1:0] RegTimeout    = 8'd3;

  localparam logic [15:0] StartLowReset    = 16'd10000;
  localparam logic [7:0]  ReleaseHighReset = 8'd40;
  localparam logic [7:0]  OneThreshReset   = 8'd50;
  localparam logic [15:0] TimeoutReset     = 16'd5000;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusChecksum = 2'd1,
    StatusZeroTemp = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] start_low;
    logic [7:0]  release_high;
    logic [7:0]  one_thresh;
    logic [15:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic drive_enable;
    logic drive_level;
    logic busy;
    logic done;
  } drive_t;

endpackage

/* rtl/core/sfr_seq.sv */
// ----------------------------------------------------------------------------
// sfr_seq
// Line sequencer: start pulse, acknowledge waits and pulse timing of the frame.
// ----------------------------------------------------------------------------
module sfr_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                start_i,
  input  logic                                line_i,
  input  sfr_pkg::cfg_t                       cfg_i,
  output sfr_pkg::drive_t                     drive_o,
  output logic [sfr_pkg::FrameBits-1:0]       frame_o
);

  localparam logic [3:0] PhIdle  = 4'd0;
  localparam logic [3:0] PhLow   = 4'd1;
  localparam logic [3:0] PhHigh  = 4'd2;
  localparam logic [3:0] PhAck0  = 4'd3;
  localparam logic [3:0] PhAck1  = 4'd4;
  localparam logic [3:0] PhAck2  = 4'd5;
  localparam logic [3:0] PhBitHi = 4'd6;
  localparam logic [3:0] PhBitLo = 4'd7;

  localparam logic [5:0] LastBit = 6'(sfr_pkg::FrameBits);

  logic [3:0]                        phase_q, phase_d;
  logic [15:0]                       tick_q, tick_d;
  logic [5:0]                        bit_idx_q, bit_idx_d;
  logic [sfr_pkg::FrameBits-1:0]     frame_q, frame_d;

  logic [15:0] tick_inc;
  logic [15:0] drive_lim;
  logic        expect_lvl;
  logic        wait_end;
  logic [15:0] width;
  logic [7:0]  width_sat;
  logic [5:0]  bit_idx_inc;

  always_comb begin
    tick_inc    = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
    drive_lim   = (phase_q == PhLow) ? cfg_i.start_low : {8'd0, cfg_i.release_high};
    expect_lvl  = (phase_q == PhAck1) || (phase_q == PhBitHi);
    wait_end    = (line_i == expect_lvl) || (tick_q >= cfg_i.timeout);
    width       = (line_i == expect_lvl) ? tick_q : 16'd0;
    width_sat   = (width > 16'd255) ? 8'hFF : width[7:0];
    bit_idx_inc = bit_idx_q + 6'd1;
  end

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_idx_d = bit_idx_q;
    frame_d   = frame_q;
    drive_o   = '{drive_enable: 1'b0, drive_level: 1'b0, busy: 1'b1, done: 1'b0};
    unique case (phase_q)
      PhLow, PhHigh: begin
        drive_o.drive_enable = 1'b1;
        drive_o.drive_level  = (phase_q == PhHigh);
        if (tick_inc >= drive_lim) begin
          phase_d = (phase_q == PhLow) ? PhHigh : PhAck0;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhAck0, PhAck1, PhAck2, PhBitHi: begin
        if (wait_end) begin
          phase_d = (phase_q == PhAck2) ? PhBitHi : phase_q + 4'd1;
          tick_d  = '0;
        end else begin
          tick_d = tick_q + 16'd1;
        end
      end
      PhBitLo: begin
        if (wait_end) begin
          frame_d = {frame_q[sfr_pkg::FrameBits-2:0], (width_sat > cfg_i.one_thresh)};
          tick_d  = '0;
          if (bit_idx_inc >= LastBit) begin
            drive_o.done = 1'b1;
            phase_d      = PhIdle;
            bit_idx_d    = '0;
          end else begin
            phase_d   = PhBitHi;
            bit_idx_d = bit_idx_inc;
          end
        end else begin
          tick_d = tick_q + 16'd1;
        end
      end
      default: begin
        drive_o = '{drive_enable: 1'b1, drive_level: 1'b1, busy: 1'b0, done: 1'b0};
        phase_d = PhIdle;
        if (start_i) begin
          phase_d   = PhLow;
          tick_d    = '0;
          bit_idx_d = '0;
          frame_d   = '0;
        end
      end
    endcase
  end

  assign frame_o = frame_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      tick_q    <= '0;
      bit_idx_q <= '0;
      frame_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_idx_q <= bit_idx_d;
      frame_q   <= frame_d;
    end
  end

endmodule

/* rtl/core/sfr_decode.sv */
// ----------------------------------------------------------------------------
// sfr_decode
// Frame decoder: byte-sum checksum and sign-magnitude temperature.
// ----------------------------------------------------------------------------
module sfr_decode (
  input  logic [sfr_pkg::FrameBits-1:0] frame_i,
  output sfr_pkg::status_e              status_o,
  output logic [15:0]                   humidity_o,
  output logic signed [15:0]            temperature_o
);

  logic [7:0]  b0, b1, b2, b3, b4;
  logic [7:0]  sum;
  logic [14:0] mag;

  always_comb begin
    b0  = frame_i[39:32];
    b1  = frame_i[31:24];
    b2  = frame_i[23:16];
    b3  = frame_i[15:8];
    b4  = frame_i[7:0];
    sum = b0 + b1 + b2 + b3;
    mag = {b2[6:0], b3};
    status_o      = sfr_pkg::StatusOk;
    humidity_o    = '0;
    temperature_o = '0;
    if (b4 != sum) begin
      status_o = sfr_pkg::StatusChecksum;
    end else if (mag == 15'd0) begin
      status_o = sfr_pkg::StatusZeroTemp;
    end else begin
      humidity_o    = {b0, b1};
      temperature_o = b2[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

/* rtl/core/single_wire_sensor_frame_reader_unit.sv */
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_reader_unit
// Single-wire sensor frame reader: one line sample per transfer, one result
// per transfer.
// ----------------------------------------------------------------------------
// The result of an input transfer is in the output register in the cycle after it.
// Throughput: 1 transfer per cycle; sequencer state and result register advance
// together, so input is taken while m_axis_tready is low only if the result
// register is empty.
// Reset: sequencer idle, counters and last reading cleared, configuration at
// its defaults, output register empty.
// ----------------------------------------------------------------------------
module single_wire_sensor_frame_reader_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // start_request, line_level
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // drive_enable, drive_level, busy_res, done_res, status[1:0],
  // humidity_tenths[15:0], temperature_tenths[15:0]
  output logic [39:0]                  m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfr_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CfgDataW-1:0] cfg_data_i
);

  sfr_pkg::cfg_t     cfg_q;
  sfr_pkg::drive_t   drive;
  sfr_pkg::status_e  dec_status;
  logic [sfr_pkg::FrameBits-1:0] frame;
  logic [15:0]        dec_hum;
  logic signed [15:0] dec_temp;

  logic [1:0]         last_status_q;
  logic [15:0]        last_hum_q;
  logic [15:0]        last_temp_q;
  logic [1:0]         status_d;
  logic [15:0]        hum_d;
  logic [15:0]        temp_d;

  logic               out_valid_q, out_valid_d;
  logic [39:0]        out_data_q;
  logic               step;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low    <= sfr_pkg::StartLowReset;
      cfg_q.release_high <= sfr_pkg::ReleaseHighReset;
      cfg_q.one_thresh   <= sfr_pkg::OneThreshReset;
      cfg_q.timeout      <= sfr_pkg::TimeoutReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sfr_pkg::RegStartLow:    cfg_q.start_low    <= cfg_data_i;
        sfr_pkg::RegReleaseHigh: cfg_q.release_high <= cfg_data_i[7:0];
        sfr_pkg::RegOneThresh:   cfg_q.one_thresh   <= cfg_data_i[7:0];
        sfr_pkg::RegTimeout:     cfg_q.timeout      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfr_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .start_i (s_axis_tdata[0]),
    .line_i  (s_axis_tdata[1]),
    .cfg_i   (cfg_q),
    .drive_o (drive),
    .frame_o (frame)
  );

  sfr_decode u_decode (
    .frame_i       (frame),
    .status_o      (dec_status),
    .humidity_o    (dec_hum),
    .temperature_o (dec_temp)
  );

  always_comb begin
    status_d = last_status_q;
    hum_d    = last_hum_q;
    temp_d   = last_temp_q;
    if (drive.done) begin
      status_d = dec_status;
      hum_d    = dec_hum;
      temp_d   = dec_temp;
    end
    out_valid_d = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_status_q <= '0;
      last_hum_q    <= '0;
      last_temp_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        last_status_q <= status_d;
        last_hum_q    <= hum_d;
        last_temp_q   <= temp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {2'b00, temp_d, hum_d, status_d, drive.done, drive.busy,
                     drive.drive_level, drive.drive_enable};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[3] |-> out_data_q[2])
    else $error("done result without busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_status_q != 2'd3)
    else $error("unused status code");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[3] && out_data_q[5:4] != sfr_pkg::StatusOk
      |-> out_data_q[37:6] == 32'd0)
    else $error("error reading with nonzero values");

  a_drive_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q[0] |-> !out_data_q[1] && out_data_q[2])
    else $error("released line outside a reading");
`endif

endmodule
